@@ hdl/pss_pkg.sv @@
`timescale 1ns / 1ps

package pss_pkg;

  // Width of the op, line and offset counters; the output count is one bit wider.
  localparam int CountBits = 20;
  localparam int TotBits   = CountBits + 1;

  typedef enum logic [1:0] {
    KindChar   = 2'd0,
    KindAttach = 2'd1,
    KindTerm   = 2'd2
  } kind_e;

  // One result as it leaves the block.
  typedef struct packed {
    kind_e                kind;
    logic [7:0]           out_char;
    logic [CountBits-1:0] op_number;
    logic [CountBits-1:0] line_number;
    logic [CountBits-1:0] offset;
    logic [TotBits-1:0]   total_count;
  } result_t;

  // Results of one core cycle. A second result, when present, is always a character.
  typedef struct packed {
    logic [1:0] count;
    logic       run_last;
    result_t    first;
    logic [7:0] second_char;
  } bundle_t;

endpackage

@@ hdl/pss_core.sv @@
`timescale 1ns / 1ps

module pss_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  input  logic [7:0]       item_byte_i,
  input  logic             item_last_i,
  input  logic             push_ready_i,
  output logic             item_take_o,
  output logic             push_valid_o,
  output pss_pkg::bundle_t push_bundle_o
);
  import pss_pkg::*;

  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChHash      = 8'h23;
  localparam logic [7:0] ChColon     = 8'h3A;
  localparam logic [7:0] ChDquote    = 8'h22;
  localparam logic [7:0] ChSquote    = 8'h27;
  localparam logic [7:0] ChBackslash = 8'h5C;

  typedef enum logic [3:0] {
    ModeNormal  = 4'b0001,
    ModeComment = 4'b0010,
    ModeString  = 4'b0100,
    ModeDoc     = 4'b1000
  } mode_e;

  function automatic logic [CountBits-1:0] sat_cnt(input logic [CountBits-1:0] x,
                                                   input logic [1:0] d);
    logic [CountBits:0] s;
    s = {1'b0, x} + {{(CountBits-1){1'b0}}, d};
    return s[CountBits] ? {CountBits{1'b1}} : s[CountBits-1:0];
  endfunction

  function automatic logic [TotBits-1:0] sat_tot(input logic [TotBits-1:0] x,
                                                 input logic [1:0] d);
    logic [TotBits:0] s;
    s = {1'b0, x} + {{(TotBits-1){1'b0}}, d};
    return s[TotBits] ? {TotBits{1'b1}} : s[TotBits-1:0];
  endfunction

  mode_e                mode_q, mode_d;
  logic [7:0]           quote_q, quote_d;
  logic                 esc_q, esc_d;
  logic [1:0]           qmc_q, qmc_d;
  logic [1:0][7:0]      la_q, la_d;
  logic [1:0]           fill_q, fill_d;
  logic                 als_q, als_d;
  logic                 be_q, be_d;
  logic [CountBits-1:0] line_q, line_d;
  logic [CountBits-1:0] op_q, op_d;
  logic [CountBits-1:0] off_q, off_d;
  logic [TotBits-1:0]   outc_q, outc_d;
  logic                 flush_q, flush_d;

  // Window of bytes seen by the byte processor.
  logic [2:0][7:0] qv;
  logic [1:0]      cnt;
  logic            has2;

  // Byte processor results.
  mode_e                p_mode;
  logic [7:0]           p_quote;
  logic                 p_esc;
  logic [1:0]           p_qmc;
  logic                 p_als;
  logic                 p_be;
  logic [CountBits-1:0] p_line;
  logic [CountBits-1:0] p_op;
  logic [TotBits-1:0]   p_outc;
  logic [1:0]           p_used;
  bundle_t              p_bundle;

  always_comb begin
    qv = '0;
    if (flush_q) begin
      qv[0] = la_q[0];
      qv[1] = la_q[1];
      cnt   = fill_q;
    end else begin
      unique case (fill_q)
        2'd0: begin
          qv[0] = item_byte_i;
        end
        2'd1: begin
          qv[0] = la_q[0];
          qv[1] = item_byte_i;
        end
        default: begin
          qv[0] = la_q[0];
          qv[1] = la_q[1];
          qv[2] = item_byte_i;
        end
      endcase
      cnt = fill_q + 2'd1;
    end
    has2 = !flush_q && (cnt == 2'd3);
  end

  // Process the head byte of the window.
  always_comb begin
    logic run_normal;
    logic [7:0] c;
    run_normal = 1'b0;
    c          = qv[0];
    p_mode     = mode_q;
    p_quote    = quote_q;
    p_esc      = esc_q;
    p_qmc      = qmc_q;
    p_als      = als_q;
    p_be       = be_q;
    p_line     = line_q;
    p_op       = op_q;
    p_outc     = outc_q;
    p_used     = 2'd1;
    p_bundle   = '0;

    unique case (mode_q)
      ModeNormal: begin
        run_normal = 1'b1;
      end
      ModeComment: begin
        if (c == ChNewline) begin
          p_mode     = ModeNormal;
          run_normal = 1'b1;
        end
      end
      ModeString: begin
        if (c == ChNewline) begin
          p_line = sat_cnt(line_q, 2'd1);
        end
        if (esc_q) begin
          p_esc = 1'b0;
        end else if (c == ChBackslash) begin
          p_esc = 1'b1;
        end else if (c == quote_q) begin
          p_mode = ModeNormal;
        end
      end
      ModeDoc: begin
        if (c == ChNewline) begin
          p_line = sat_cnt(line_q, 2'd1);
        end
        if (c == quote_q) begin
          if (qmc_q == 2'd2) begin
            p_qmc  = 2'd0;
            p_mode = ModeNormal;
          end else begin
            p_qmc = qmc_q + 2'd1;
          end
        end else begin
          p_qmc = 2'd0;
        end
      end
      default: begin
        p_mode     = ModeNormal;
        run_normal = 1'b1;
      end
    endcase

    if (run_normal) begin
      p_bundle.first.kind = KindChar;
      priority if (c == ChDquote || c == ChSquote) begin
        p_quote = c;
        if (has2 && qv[1] == c && qv[2] == c) begin
          p_mode = ModeDoc;
          p_qmc  = 2'd0;
          p_used = 2'd3;
        end else begin
          p_mode                  = ModeString;
          p_esc                   = 1'b0;
          p_bundle.count          = 2'd2;
          p_bundle.first.out_char = c;
          p_bundle.second_char    = c;
          p_outc                  = sat_tot(outc_q, 2'd2);
        end
      end else if (c == ChHash) begin
        p_mode = ModeComment;
      end else if (c == ChSpace || c == ChTab) begin
        if (als_q) begin
          p_be                    = 1'b1;
          p_bundle.count          = 2'd1;
          p_bundle.first.out_char = c;
          p_outc                  = sat_tot(outc_q, 2'd1);
        end else if (!be_q) begin
          p_be                    = 1'b1;
          p_bundle.count          = 2'd1;
          p_bundle.first.out_char = ChSpace;
          p_outc                  = sat_tot(outc_q, 2'd1);
        end
      end else if (c == ChNewline) begin
        p_op                       = sat_cnt(op_q, 2'd1);
        p_bundle.count             = 2'd2;
        p_bundle.first.kind        = KindAttach;
        p_bundle.first.op_number   = p_op;
        p_bundle.first.line_number = line_q;
        p_bundle.first.offset      = off_q;
        p_bundle.second_char       = c;
        p_line                     = sat_cnt(line_q, 2'd1);
        p_outc                     = sat_tot(outc_q, 2'd1);
        p_als                      = 1'b1;
      end else begin
        if (c == ChColon) begin
          p_op                       = sat_cnt(op_q, 2'd1);
          p_bundle.count             = 2'd2;
          p_bundle.first.kind        = KindAttach;
          p_bundle.first.op_number   = p_op;
          p_bundle.first.line_number = line_q;
          p_bundle.first.offset      = off_q;
          p_bundle.second_char       = c;
        end else begin
          p_bundle.count          = 2'd1;
          p_bundle.first.out_char = c;
        end
        p_als  = 1'b0;
        p_be   = 1'b0;
        p_outc = sat_tot(outc_q, 2'd1);
      end
    end
  end

  // Step control: buffer, process, flush and terminate.
  always_comb begin
    logic advance;
    logic do_proc;
    logic term;
    advance = item_valid_i && push_ready_i;
    do_proc = flush_q ? (fill_q != 2'd0) : (cnt == 2'd3 || item_last_i);
    term    = flush_q && (fill_q == 2'd0);

    mode_d        = mode_q;
    quote_d       = quote_q;
    esc_d         = esc_q;
    qmc_d         = qmc_q;
    la_d          = la_q;
    fill_d        = fill_q;
    als_d         = als_q;
    be_d          = be_q;
    line_d        = line_q;
    op_d          = op_q;
    off_d         = off_q;
    outc_d        = outc_q;
    flush_d       = flush_q;
    item_take_o   = 1'b0;
    push_bundle_o = '0;

    if (advance) begin
      if (term) begin
        push_bundle_o.count             = 2'd1;
        push_bundle_o.run_last          = 1'b1;
        push_bundle_o.first.kind        = KindTerm;
        push_bundle_o.first.total_count = sat_tot(outc_q, 2'd1);
        mode_d      = ModeNormal;
        quote_d     = '0;
        esc_d       = 1'b0;
        qmc_d       = 2'd0;
        fill_d      = 2'd0;
        als_d       = 1'b1;
        be_d        = 1'b0;
        line_d      = '0;
        op_d        = '0;
        off_d       = '0;
        outc_d      = '0;
        flush_d     = 1'b0;
        item_take_o = 1'b1;
      end else begin
        if (do_proc) begin
          mode_d        = p_mode;
          quote_d       = p_quote;
          esc_d         = p_esc;
          qmc_d         = p_qmc;
          als_d         = p_als;
          be_d          = p_be;
          line_d        = p_line;
          op_d          = p_op;
          outc_d        = p_outc;
          off_d         = sat_cnt(off_q, p_used);
          push_bundle_o = p_bundle;
          if (p_used == 2'd3) begin
            fill_d = 2'd0;
          end else begin
            la_d[0] = qv[1];
            la_d[1] = qv[2];
            fill_d  = cnt - 2'd1;
          end
        end else begin
          la_d[0] = qv[0];
          la_d[1] = qv[1];
          fill_d  = cnt;
        end
        // The last item's final result is its terminator.
        push_bundle_o.run_last = !item_last_i;
        if (!flush_q) begin
          if (item_last_i) begin
            flush_d = 1'b1;
          end else begin
            item_take_o = 1'b1;
          end
        end
      end
    end
    push_valid_o = advance && (push_bundle_o.count != 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeNormal;
      quote_q <= '0;
      esc_q   <= 1'b0;
      qmc_q   <= 2'd0;
      fill_q  <= 2'd0;
      als_q   <= 1'b1;
      be_q    <= 1'b0;
      line_q  <= '0;
      op_q    <= '0;
      off_q   <= '0;
      outc_q  <= '0;
      flush_q <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      quote_q <= quote_d;
      esc_q   <= esc_d;
      qmc_q   <= qmc_d;
      fill_q  <= fill_d;
      als_q   <= als_d;
      be_q    <= be_d;
      line_q  <= line_d;
      op_q    <= op_d;
      off_q   <= off_d;
      outc_q  <= outc_d;
      flush_q <= flush_d;
    end
  end

  always_ff @(posedge clk_i) begin
    la_q <= la_d;
  end

endmodule

@@ hdl/pss_outbuf.sv @@
`timescale 1ns / 1ps

module pss_outbuf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  input  pss_pkg::bundle_t push_bundle_i,
  output logic             push_ready_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output pss_pkg::result_t out_result_o,
  output logic             out_run_last_o
);
  import pss_pkg::*;

  logic [1:0] cnt_q, cnt_d;
  logic       idx_q, idx_d;
  logic       rl_q, rl_d;
  result_t    first_q, first_d;
  logic [7:0] second_q, second_d;

  logic at_end;
  logic take;

  always_comb begin
    at_end         = idx_q || (cnt_q == 2'd1);
    out_valid_o    = (cnt_q != 2'd0);
    take           = out_valid_o && !out_stall_i;
    push_ready_o   = !out_valid_o || (take && at_end);
    out_run_last_o = rl_q && at_end;

    out_result_o = first_q;
    if (idx_q) begin
      out_result_o          = '0;
      out_result_o.kind     = KindChar;
      out_result_o.out_char = second_q;
    end

    cnt_d    = cnt_q;
    idx_d    = idx_q;
    rl_d     = rl_q;
    first_d  = first_q;
    second_d = second_q;
    if (push_valid_i) begin
      cnt_d    = push_bundle_i.count;
      idx_d    = 1'b0;
      rl_d     = push_bundle_i.run_last;
      first_d  = push_bundle_i.first;
      second_d = push_bundle_i.second_char;
    end else if (take) begin
      if (at_end) begin
        cnt_d = 2'd0;
      end else begin
        idx_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      idx_q <= 1'b0;
      rl_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
      rl_q  <= rl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q  <= first_d;
    second_q <= second_d;
  end

endmodule

@@ hdl/python_source_stripper_unit.sv @@
`timescale 1ns / 1ps
// Python source stripper: takes source one byte per request and emits the stripped
// text, an attachment record for each newline and colon in code, and a terminator.
// Input channel: in_valid_i / in_stall_o with in_byte_i and in_last_i. Output channel:
// out_valid_o / out_stall_i with one result at a time; run_last_o marks the
// final result caused by an input byte.
// A byte is released two bytes later (triple-quote lookahead); in_last_i flushes the
// window and adds the terminator. Once a request is in the input register, the byte
// it releases goes through the core into the result register that drives out_valid_o.
// The core runs one byte per cycle while the result register can take its results;
// the output register shows one result per cycle while not stalled, so a byte
// that yields two results (quotes, newline, colon) shows them in turn. The final byte
// flushes up to three window bytes and then the terminator: up to seven results.
// Reset (rst_ni low, asynchronous) empties both registers and returns the stream
// state to the start of a file; the stream state is also reset after each terminator.
// When the receiver stalls, the current result holds; at most one more request is
// taken into the input register, after which in_stall_o rises until the output drains.
module python_source_stripper_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     in_byte_i,
  input  logic                           in_last_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     kind_o,
  output logic [7:0]                     out_char_o,
  output logic [pss_pkg::CountBits-1:0]  op_number_o,
  output logic [pss_pkg::CountBits-1:0]  line_number_o,
  output logic [pss_pkg::CountBits-1:0]  offset_o,
  output logic [pss_pkg::CountBits:0]    total_count_o,
  output logic                           run_last_o
);
  import pss_pkg::*;

  // Input register: holds one request while the core works on it.
  logic       in_full_q, in_full_d;
  logic [7:0] in_byte_q, in_byte_d;
  logic       in_last_q, in_last_d;
  logic       accept;

  logic    item_take;
  logic    push_valid;
  logic    push_ready;
  bundle_t push_bundle;
  result_t out_result;

  assign in_stall_o = in_full_q && !item_take;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_full_d = in_full_q;
    in_byte_d = in_byte_q;
    in_last_d = in_last_q;
    if (accept) begin
      in_full_d = 1'b1;
      in_byte_d = in_byte_i;
      in_last_d = in_last_i;
    end else if (item_take) begin
      in_full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
    end else begin
      in_full_q <= in_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_byte_q <= in_byte_d;
    in_last_q <= in_last_d;
  end

  // Stream state, lookahead window and the per-byte rules.
  pss_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (in_full_q),
    .item_byte_i   (in_byte_q),
    .item_last_i   (in_last_q),
    .push_ready_i  (push_ready),
    .item_take_o   (item_take),
    .push_valid_o  (push_valid),
    .push_bundle_o (push_bundle)
  );

  // Result register: up to two results per core cycle, shown one at a time.
  pss_outbuf u_outbuf (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_valid_i   (push_valid),
    .push_bundle_i  (push_bundle),
    .push_ready_o   (push_ready),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_result_o   (out_result),
    .out_run_last_o (run_last_o)
  );

  assign kind_o        = out_result.kind;
  assign out_char_o    = out_result.out_char;
  assign op_number_o   = out_result.op_number;
  assign line_number_o = out_result.line_number;
  assign offset_o      = out_result.offset;
  assign total_count_o = out_result.total_count;

`ifndef NO_ASSERTIONS
  a_stall_needs_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_full_q)
    else $error("input stalled with an empty input register");

  a_term_is_run_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KindTerm) |-> run_last_o)
    else $error("terminator without run_last");

  a_char_fields_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KindChar) |->
      (op_number_o == '0 && line_number_o == '0 && offset_o == '0 && total_count_o == '0))
    else $error("character result carries record fields");
`endif

endmodule

@@ verif/tb_python_source_stripper_unit.sv @@
`timescale 1ns / 1ps

module tb_python_source_stripper_unit;
  import pss_pkg::*;

  localparam int          HalfPeriod  = 4;
  localparam int          ResetCycles = 5;
  // Window holds two bytes and the output register up to two results, so a
  // short wait after the last pending result catches anything extra.
  localparam int          DrainCycles = 16;
  // The limit allows several times the slowest correct run.
  localparam int unsigned RunLimitNs  = 5_000_000;
  localparam int unsigned HoldCycles  = 80;

  localparam logic [31:0] CntMax = (32'd1 << CountBits) - 32'd1;
  localparam logic [31:0] OutMax = (32'd1 << TotBits) - 32'd1;

  localparam logic [7:0] LF    = 8'h0A;
  localparam logic [7:0] TAB   = 8'h09;
  localparam logic [7:0] SP    = 8'h20;
  localparam logic [7:0] HASH  = 8'h23;
  localparam logic [7:0] COLON = 8'h3A;
  localparam logic [7:0] DQ    = 8'h22;
  localparam logic [7:0] SQ    = 8'h27;
  localparam logic [7:0] BSL   = 8'h5C;

  typedef enum logic [1:0] {
    ScanCode,
    ScanComment,
    ScanString,
    ScanDoc
  } scan_mode_e;

  typedef struct {
    kind_e                kind;
    logic [7:0]           ch;
    logic [CountBits-1:0] op_num;
    logic [CountBits-1:0] line_num;
    logic [CountBits-1:0] ofs;
    logic [TotBits-1:0]   total;
    logic                 last;
  } strip_result_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic [7:0]           in_byte_i   = 8'h00;
  logic                 in_last_i   = 1'b0;
  logic                 out_stall_i = 1'b0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  logic [1:0]           kind_o;
  logic [7:0]           out_char_o;
  logic [CountBits-1:0] op_number_o;
  logic [CountBits-1:0] line_number_o;
  logic [CountBits-1:0] offset_o;
  logic [CountBits:0]   total_count_o;
  logic                 run_last_o;

  python_source_stripper_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .in_last_i     (in_last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .out_char_o    (out_char_o),
    .op_number_o   (op_number_o),
    .line_number_o (line_number_o),
    .offset_o      (offset_o),
    .total_count_o (total_count_o),
    .run_last_o    (run_last_o)
  );

  always begin
    #HalfPeriod clk_i = 1'b1;
    #HalfPeriod clk_i = 1'b0;
  end

  initial begin
    #(RunLimitNs);
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Stripper state as seen from outside: scan mode, quote tracking, the
  // two-byte lookahead window, blank/line-start flags and the counters.
  // ---------------------------------------------------------------------
  scan_mode_e           scan_mode;
  logic [7:0]           open_quote;
  logic                 escaped;
  logic [1:0]           close_run;
  logic [7:0]           window [2];
  int unsigned          window_fill;
  logic                 line_start;
  logic                 blank_done;
  logic [CountBits-1:0] line_cnt;
  logic [CountBits-1:0] op_cnt;
  logic [CountBits-1:0] byte_ofs;
  logic [TotBits-1:0]   text_len;

  // Stripped results still to come out of the block, oldest first.
  strip_result_t        stripped_q [$];
  int unsigned          step_results;
  int unsigned          mismatch_count = 0;

  // Idle controls shared by the test tasks, the request sender and the output stall process.
  bit                   feed_gaps_on   = 1'b0;
  bit                   sink_stalls_on = 1'b0;
  int unsigned          sink_hold_cycles = 0;

  logic [7:0]           src_buf [$];

  function automatic logic [31:0] sat_add(logic [31:0] v, int unsigned d, logic [31:0] top);
    return (v >= top || top - v < d) ? top : v + d;
  endfunction

  function automatic void strip_reset();
    scan_mode   = ScanCode;
    open_quote  = 8'h00;
    escaped     = 1'b0;
    close_run   = 2'd0;
    window[0]   = 8'h00;
    window[1]   = 8'h00;
    window_fill = 0;
    line_start  = 1'b1;
    blank_done  = 1'b0;
    line_cnt    = '0;
    op_cnt      = '0;
    byte_ofs    = '0;
    text_len    = '0;
  endfunction

  function automatic void push_result(kind_e kind, logic [7:0] ch, logic [CountBits-1:0] op,
                                      logic [CountBits-1:0] ln, logic [CountBits-1:0] ofs,
                                      logic [TotBits-1:0] total);
    strip_result_t r;
    r.kind     = kind;
    r.ch       = ch;
    r.op_num   = op;
    r.line_num = ln;
    r.ofs      = ofs;
    r.total    = total;
    r.last     = 1'b0;
    stripped_q.push_back(r);
    step_results++;
  endfunction

  function automatic void put_char(logic [7:0] c);
    text_len = TotBits'(sat_add(32'(text_len), 1, OutMax));
    push_result(KindChar, c, '0, '0, '0, '0);
  endfunction

  function automatic void put_attach();
    op_cnt = CountBits'(sat_add(32'(op_cnt), 1, CntMax));
    push_result(KindAttach, 8'h00, op_cnt, line_cnt, byte_ofs, '0);
  endfunction

  // Handles the byte at the head of the window; returns how many bytes it used
  // (three when a triple quote opens a docstring).
  function automatic int unsigned scan_byte(logic [7:0] c, bit has2, logic [7:0] b1,
                                            logic [7:0] b2);
    case (scan_mode)
      ScanComment: begin
        if (c != LF) return 1;
        // newline closes the comment and is then handled as code
        scan_mode = ScanCode;
      end
      ScanString: begin
        if (c == LF) line_cnt = CountBits'(sat_add(32'(line_cnt), 1, CntMax));
        if (escaped) escaped = 1'b0;
        else if (c == BSL) escaped = 1'b1;
        else if (c == open_quote) scan_mode = ScanCode;
        return 1;
      end
      ScanDoc: begin
        if (c == LF) line_cnt = CountBits'(sat_add(32'(line_cnt), 1, CntMax));
        // only three of the opening quote in a row close it; escapes do nothing
        if (c == open_quote) begin
          close_run++;
          if (close_run == 2'd3) begin
            close_run = 2'd0;
            scan_mode = ScanCode;
          end
        end else begin
          close_run = 2'd0;
        end
        return 1;
      end
      default: ;
    endcase

    if (c == DQ || c == SQ) begin
      open_quote = c;
      if (has2 && b1 == c && b2 == c) begin
        scan_mode = ScanDoc;
        close_run = 2'd0;
        return 3;
      end
      scan_mode = ScanString;
      escaped   = 1'b0;
      put_char(c);
      put_char(c);
      return 1;
    end
    if (c == HASH) begin
      scan_mode = ScanComment;
      return 1;
    end
    if (c == SP || c == TAB) begin
      if (line_start) begin
        blank_done = 1'b1;
        put_char(c);
      end
      if (!blank_done) begin
        blank_done = 1'b1;
        put_char(SP);
      end
      return 1;
    end
    if (c == LF) begin
      put_attach();
      line_cnt = CountBits'(sat_add(32'(line_cnt), 1, CntMax));
      put_char(c);
      line_start = 1'b1;
      return 1;
    end
    if (c == COLON) put_attach();
    line_start = 1'b0;
    blank_done = 1'b0;
    put_char(c);
    return 1;
  endfunction

  // Works out every result caused by one accepted request.
  function automatic void strip_step(logic [7:0] b, bit last);
    logic [7:0]    q [3];
    int unsigned   cnt;
    int unsigned   pos;
    int unsigned   used;
    bit            has2;
    logic [7:0]    b1;
    logic [7:0]    b2;
    strip_result_t r;
    cnt          = 0;
    pos          = 0;
    step_results = 0;
    for (int k = 0; k < window_fill; k++) begin
      q[cnt] = window[k];
      cnt++;
    end
    q[cnt] = b;
    cnt++;
    // a byte is handled once two later bytes are known, or at the final byte
    while (cnt - pos >= 3 || (last && cnt > pos)) begin
      has2 = (cnt - pos >= 3);
      b1   = 8'h00;
      b2   = 8'h00;
      if (has2) begin
        b1 = q[pos+1];
        b2 = q[pos+2];
      end
      used     = scan_byte(q[pos], has2, b1, b2);
      byte_ofs = CountBits'(sat_add(32'(byte_ofs), used, CntMax));
      pos += used;
    end
    if (last) begin
      push_result(KindTerm, 8'h00, '0, '0, '0, TotBits'(sat_add(32'(text_len), 1, OutMax)));
      strip_reset();
    end else begin
      window_fill = cnt - pos;
      for (int k = 0; k < window_fill; k++) window[k] = q[pos+k];
    end
    if (step_results > 0) begin
      r      = stripped_q.pop_back();
      r.last = 1'b1;
      stripped_q.push_back(r);
    end
  endfunction

  // Mostly no idle, some short, a few long.
  function automatic int unsigned pick_idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // ---------------------------------------------------------------------
  // Result check: every result taken from the block is compared with the
  // oldest pending one. Outputs are read just after the edge, which is the
  // value they held at the edge.
  // ---------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    strip_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (stripped_q.size() == 0) begin
        $error("unexpected result: kind %0d char %0d", kind_o, out_char_o);
        mismatch_count++;
      end else begin
        want = stripped_q.pop_front();
        check_field("kind", 32'(want.kind), 32'(kind_o));
        check_field("out_char", 32'(want.ch), 32'(out_char_o));
        check_field("op_number", 32'(want.op_num), 32'(op_number_o));
        check_field("line_number", 32'(want.line_num), 32'(line_number_o));
        check_field("offset", 32'(want.ofs), 32'(offset_o));
        check_field("total_count", 32'(want.total), 32'(total_count_o));
        check_field("run_last", 32'(want.last), 32'(run_last_o));
      end
    end
  end

  // Output side: random stalls when enabled, plus a long hold-off on demand.
  initial begin : sink_stall_gen
    int unsigned n;
    forever begin
      if (sink_hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (sink_hold_cycles) @(posedge clk_i);
        sink_hold_cycles = 0;
      end else begin
        n = sink_stalls_on ? pick_idle_len() : 0;
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  // One request: optional idle gap, then hold the byte until it is taken.
  // Valid is only lowered when a gap follows, so it is never dropped and
  // raised in the same step.
  task automatic send_byte(logic [7:0] b, bit last);
    int unsigned gap;
    gap = feed_gaps_on ? pick_idle_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    in_last_i  <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    strip_step(b, last);
  endtask

  // Sends src_buf as one stream; the final byte carries in_last.
  task automatic send_buf();
    foreach (src_buf[i]) send_byte(src_buf[i], i == src_buf.size() - 1);
  endtask

  task automatic send_text(string s);
    src_buf.delete();
    for (int i = 0; i < s.len(); i++) src_buf.push_back(s[i]);
    send_buf();
  endtask

  // Appends one Python-like token; a few are noise or broken constructs.
  function automatic void add_token();
    int unsigned pick;
    int unsigned n;
    logic [7:0]  qc;
    string       punct;
    punct = "()[]=,.+";
    pick  = $urandom_range(0, 99);
    qc    = $urandom_range(0, 1) ? DQ : SQ;
    if (pick < 20) begin
      n = $urandom_range(1, 5);
      repeat (n) src_buf.push_back(8'($urandom_range(97, 122)));
    end else if (pick < 32) begin
      n = $urandom_range(1, 3);
      repeat (n) src_buf.push_back($urandom_range(0, 1) ? SP : TAB);
    end else if (pick < 44) begin
      src_buf.push_back(LF);
      n = $urandom_range(0, 3);
      repeat (n) src_buf.push_back($urandom_range(0, 3) == 0 ? TAB : SP);
    end else if (pick < 52) begin
      src_buf.push_back(COLON);
    end else if (pick < 60) begin
      src_buf.push_back(HASH);
      n = $urandom_range(0, 4);
      repeat (n) src_buf.push_back(8'($urandom_range(32, 126)));
    end else if (pick < 72) begin
      // string with escapes and embedded newlines; now and then left open
      src_buf.push_back(qc);
      n = $urandom_range(0, 5);
      repeat (n) begin
        case ($urandom_range(0, 4))
          0: begin
            src_buf.push_back(BSL);
            src_buf.push_back($urandom_range(0, 1) ? qc : 8'($urandom_range(32, 126)));
          end
          1: src_buf.push_back(LF);
          2: src_buf.push_back(qc == DQ ? SQ : DQ);
          default: src_buf.push_back(8'($urandom_range(97, 122)));
        endcase
      end
      if ($urandom_range(0, 9) != 0) src_buf.push_back(qc);
    end else if (pick < 82) begin
      // docstring with stray quotes, backslashes and newlines inside
      repeat (3) src_buf.push_back(qc);
      n = $urandom_range(0, 6);
      repeat (n) begin
        case ($urandom_range(0, 5))
          0: src_buf.push_back(qc);
          1: src_buf.push_back(qc == DQ ? SQ : DQ);
          2: src_buf.push_back(LF);
          3: src_buf.push_back(BSL);
          default: src_buf.push_back(8'($urandom_range(97, 122)));
        endcase
      end
      if ($urandom_range(0, 9) != 0) repeat (3) src_buf.push_back(qc);
    end else if (pick < 90) begin
      src_buf.push_back(punct[$urandom_range(0, punct.len() - 1)]);
    end else if (pick < 94) begin
      src_buf.push_back(qc);
    end else begin
      src_buf.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic send_random(int unsigned n_bytes);
    int unsigned sent;
    int unsigned n_tok;
    sent = 0;
    while (sent < n_bytes) begin
      src_buf.delete();
      n_tok = $urandom_range(1, 12);
      repeat (n_tok) add_token();
      sent += src_buf.size();
      send_buf();
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Hand-picked streams: leading blanks and a collapsed run, colon record,
  // comment closed by a newline, escaped quote and newline inside a string,
  // docstring holding the other quote and a backslash, extreme byte values,
  // and two quotes at the very end that open an ordinary string.
  task automatic test_directed_cases();
    feed_gaps_on   = 1'b1;
    sink_stalls_on = 1'b1;
    send_text(" \tx  :#\n");
    send_text("'a\\'\n'");
    send_text("\"\"\"'\\\"\"\"");
    src_buf = '{8'h00, 8'hFF};
    send_buf();
    send_text("''");
  endtask

  task automatic test_streaming_no_idle();
    feed_gaps_on   = 1'b0;
    sink_stalls_on = 1'b0;
    send_random(60);
  endtask

  task automatic test_streaming_with_gaps();
    feed_gaps_on   = 1'b1;
    sink_stalls_on = 1'b1;
    send_random(160);
  endtask

  task automatic test_output_stalls();
    feed_gaps_on   = 1'b0;
    sink_stalls_on = 1'b1;
    send_random(60);
  endtask

  // Receiver holds off for a long stretch while requests keep coming, so the
  // block fills and raises in_stall_o.
  task automatic test_backpressure();
    feed_gaps_on     = 1'b0;
    sink_stalls_on   = 1'b0;
    sink_hold_cycles = HoldCycles;
    send_random(30);
  endtask

  initial begin
    strip_reset();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_streaming_no_idle();
    test_streaming_with_gaps();
    test_output_stalls();
    test_backpressure();

    in_valid_i     <= 1'b0;
    sink_stalls_on = 1'b0;
    while (stripped_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/pss_pkg.sv
hdl/pss_core.sv
hdl/pss_outbuf.sv
hdl/python_source_stripper_unit.sv
verif/tb_python_source_stripper_unit.sv
